[hw/rtl/i2cee_pkg.sv]
// shared types and constants for the i2c eeprom master
package i2cee_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_READ   = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_SUPPLY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_DEV     = 2'd0,
    REG_STRETCH = 2'd1,
    REG_POLLS   = 2'd2,
    REG_PWAIT   = 2'd3
  } reg_e;

  typedef enum logic [28:0] {
    PH_IDLE = 29'h0000001,
    PH_NEED = 29'h0000002,
    PH_WAIT = 29'h0000004,
    PH_V0   = 29'h0000008,
    PH_V1   = 29'h0000010,
    PH_V2   = 29'h0000020,
    PH_V3   = 29'h0000040,
    PH_V4   = 29'h0000080,
    PH_S0   = 29'h0000100,
    PH_S1   = 29'h0000200,
    PH_S2   = 29'h0000400,
    PH_S3   = 29'h0000800,
    PH_P0   = 29'h0001000,
    PH_P1   = 29'h0002000,
    PH_P2   = 29'h0004000,
    PH_P3   = 29'h0008000,
    PH_B0   = 29'h0010000,
    PH_B1   = 29'h0020000,
    PH_B2   = 29'h0040000,
    PH_A0   = 29'h0080000,
    PH_A1   = 29'h0100000,
    PH_A2   = 29'h0200000,
    PH_R0   = 29'h0400000,
    PH_R1   = 29'h0800000,
    PH_R2   = 29'h1000000,
    PH_R3   = 29'h2000000,
    PH_R4   = 29'h4000000,
    PH_R5   = 29'h8000000,
    PH_R6   = 29'h10000000
  } phase_e;

  typedef enum logic [14:0] {
    SQ_REC     = 15'h0001,
    SQ_START1  = 15'h0002,
    SQ_DEVW    = 15'h0004,
    SQ_AHI     = 15'h0008,
    SQ_ALO     = 15'h0010,
    SQ_START2  = 15'h0020,
    SQ_DEVR    = 15'h0040,
    SQ_RDATA   = 15'h0080,
    SQ_STOPEND = 15'h0100,
    SQ_WDATA   = 15'h0200,
    SQ_WSTOP   = 15'h0400,
    SQ_PWAIT   = 15'h0800,
    SQ_PSTART  = 15'h1000,
    SQ_PDEV    = 15'h2000,
    SQ_PSTOP   = 15'h4000
  } step_e;

  localparam int unsigned CFG_W = 12;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [14:0] mem_address;
    logic [15:0] length;
    logic [7:0]  wdata;
    logic        scl_in;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       write_protect;
    logic [7:0] rdata;
    logic       rdata_valid;
    logic       need_data;
    logic       done_res;
    logic       success;
    logic       busy_res;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [9:0]  stretch_limit;
    logic [5:0]  poll_attempts;
    logic [11:0] poll_wait_ticks;
  } cfg_t;

endpackage

[hw/rtl/i2c_eeprom_master.sv]
// top level of the i2c eeprom master
//  channel | direction | handshake
//  in      | input     | in_valid_i / in_stall_o
//  out     | output    | out_valid_o / out_stall_i
//  cfg     | input     | cfg_we_i, cfg_index_i, cfg_wdata_i
// one item per cycle while in_stall_o is low: the sequencer steps once per
// accepted transfer and the result is written to the output register at that
// edge, valid the next cycle. in_stall_o is high only while a result waits and
// out_stall_i holds it; an item is taken in the same cycle the waiting result
// leaves. reset zeroes the result; inner scl, sda and write protect start high
module i2c_eeprom_master #(
  parameter int unsigned PAGE_SIZE = 64,
  parameter int unsigned MEM_BYTES = 32768
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  i2cee_pkg::in_item_t         in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output i2cee_pkg::out_item_t        out_data_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [i2cee_pkg::CFG_W-1:0] cfg_wdata_i
);
  i2cee_pkg::cfg_t      cfg;
  i2cee_pkg::out_item_t res;
  logic                 step, res_vld_q;

  // stall only when the output register is full and held
  assign in_stall_o  = res_vld_q && out_stall_i;
  assign step        = in_valid_i && !in_stall_o;
  assign out_valid_o = res_vld_q;
  assign out_data_o  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_vld_q <= 1'b0;
    else if (step) res_vld_q <= 1'b1;
    else if (!out_stall_i) res_vld_q <= 1'b0;
  end

  i2cee_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i, .cfg_o(cfg)
  );

  i2cee_seq #(.PAGE_SIZE(PAGE_SIZE), .MEM_BYTES(MEM_BYTES)) u_seq (
    .clk_i, .rst_ni, .step_i(step), .item_i(in_data_i), .cfg_i(cfg), .res_o(res)
  );
endmodule

[hw/rtl/i2cee_cfg.sv]
// configuration register file
module i2cee_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [i2cee_pkg::CFG_W-1:0] cfg_wdata_i,
  output i2cee_pkg::cfg_t             cfg_o
);
  i2cee_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address  <= 7'd80;
      cfg_q.stretch_limit   <= 10'd200;
      cfg_q.poll_attempts   <= 6'd20;
      cfg_q.poll_wait_ticks <= 12'd100;
    end else if (cfg_we_i) begin
      unique case (i2cee_pkg::reg_e'(cfg_index_i))
        i2cee_pkg::REG_DEV:     cfg_q.device_address  <= cfg_wdata_i[6:0];
        i2cee_pkg::REG_STRETCH: cfg_q.stretch_limit   <= cfg_wdata_i[9:0];
        i2cee_pkg::REG_POLLS:   cfg_q.poll_attempts   <= cfg_wdata_i[5:0];
        i2cee_pkg::REG_PWAIT:   cfg_q.poll_wait_ticks <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;
endmodule

[hw/rtl/i2cee_seq.sv]
// bus sequencer: one phase step per accepted item, result registered
module i2cee_seq #(
  parameter int unsigned PAGE_SIZE = 64,
  parameter int unsigned MEM_BYTES = 32768
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  i2cee_pkg::in_item_t  item_i,
  input  i2cee_pkg::cfg_t      cfg_i,
  output i2cee_pkg::out_item_t res_o
);
  localparam int unsigned PW = $clog2(PAGE_SIZE + 1);

  i2cee_pkg::phase_e ph_q, ph_d;
  i2cee_pkg::step_e  sq_q, sq_d;
  logic [11:0] wc_q, wc_d;
  logic [3:0]  bc_q, bc_d;
  logic [7:0]  sb_q, sb_d;
  logic [14:0] ca_q, ca_d;
  logic [15:0] bl_q, bl_d;
  logic [PW-1:0] pl_q, pl_d;
  logic [5:0]  pc_q, pc_d;
  logic        ok_q, ok_d, wr_q, wr_d, rdy_q, rdy_d, sok_q, sok_d;
  logic        scl_q, scl_d, sda_q, sda_d, wp_q, wp_d;

  // combinational scratch
  logic pd, pr, cdone, cto, pend_done, pend_succ, pend_valid;
  logic [7:0] pend_rd;
  logic [16:0] endaddr;

  function automatic logic [7:0] devb(logic [6:0] a, logic rd);
    devb = {a, rd};
  endfunction

  function automatic logic [PW-1:0] page_of(logic [14:0] ca, logic [15:0] bl);
    logic [16:0] rm;
    rm = 17'(PAGE_SIZE) - 17'(ca % 15'(PAGE_SIZE));
    page_of = ({1'b0, bl} < rm) ? PW'(bl) : PW'(rm);
  endfunction

  always_comb begin
    ph_d = ph_q; sq_d = sq_q; wc_d = wc_q; bc_d = bc_q; sb_d = sb_q;
    ca_d = ca_q; bl_d = bl_q; pl_d = pl_q; pc_d = pc_q; ok_d = ok_q;
    wr_d = wr_q; rdy_d = rdy_q; sok_d = sok_q;
    scl_d = scl_q; sda_d = sda_q; wp_d = wp_q;
    pd = 1'b0; pr = 1'b0;
    pend_done = 1'b0; pend_succ = 1'b0; pend_valid = 1'b0; pend_rd = 8'd0;
    endaddr = 17'(item_i.mem_address) + 17'(item_i.length);
    // clock stretch check
    cdone = item_i.scl_in;
    cto = !item_i.scl_in && (wc_q >= 12'(cfg_i.stretch_limit));

    unique case (i2cee_pkg::cmd_e'(item_i.cmd))
      i2cee_pkg::CMD_TICK: begin
        if (!cdone && !cto) wc_d = wc_q + 12'd1;
        unique case (ph_q)
          i2cee_pkg::PH_WAIT: begin
            wc_d = wc_q + 12'd1;
            if (wc_d >= cfg_i.poll_wait_ticks) begin pd = 1'b1; pr = 1'b1; end
          end
          i2cee_pkg::PH_V0: begin
            sda_d = 1'b1; scl_d = 1'b1; wc_d = '0; ph_d = i2cee_pkg::PH_V1;
          end
          i2cee_pkg::PH_V1: begin
            if (cto) pd = 1'b1;
            else if (cdone) begin
              if (item_i.sda_in) begin pd = 1'b1; pr = 1'b1; end
              else begin bc_d = '0; ph_d = i2cee_pkg::PH_V2; end
            end
          end
          i2cee_pkg::PH_V2: begin scl_d = 1'b0; ph_d = i2cee_pkg::PH_V3; end
          i2cee_pkg::PH_V3: begin scl_d = 1'b1; wc_d = '0; ph_d = i2cee_pkg::PH_V4; end
          i2cee_pkg::PH_V4: begin
            if (cto) pd = 1'b1;
            else if (cdone) begin
              bc_d = bc_q + 4'd1;
              ph_d = (bc_d >= 4'd9) ? i2cee_pkg::PH_P0 : i2cee_pkg::PH_V2;
            end
          end
          i2cee_pkg::PH_S0: begin sda_d = 1'b1; ph_d = i2cee_pkg::PH_S1; end
          i2cee_pkg::PH_S1: begin scl_d = 1'b1; wc_d = '0; ph_d = i2cee_pkg::PH_S2; end
          i2cee_pkg::PH_S2: begin
            if (cto) pd = 1'b1;
            else if (cdone) begin
              if (!item_i.sda_in) pd = 1'b1;
              else begin sda_d = 1'b0; ph_d = i2cee_pkg::PH_S3; end
            end
          end
          i2cee_pkg::PH_S3: begin scl_d = 1'b0; pd = 1'b1; pr = 1'b1; end
          i2cee_pkg::PH_P0: begin
            scl_d = 1'b0; sda_d = 1'b0; ph_d = i2cee_pkg::PH_P1;
          end
          i2cee_pkg::PH_P1: begin scl_d = 1'b1; wc_d = '0; ph_d = i2cee_pkg::PH_P2; end
          i2cee_pkg::PH_P2: begin
            if (cdone || cto) begin
              sok_d = cdone; sda_d = 1'b1; ph_d = i2cee_pkg::PH_P3;
            end
          end
          i2cee_pkg::PH_P3: begin pd = 1'b1; pr = sok_q && item_i.sda_in; end
          i2cee_pkg::PH_B0: begin
            scl_d = 1'b0; sda_d = sb_q[7]; ph_d = i2cee_pkg::PH_B1;
          end
          i2cee_pkg::PH_B1: begin scl_d = 1'b1; wc_d = '0; ph_d = i2cee_pkg::PH_B2; end
          i2cee_pkg::PH_B2: begin
            if (cto) pd = 1'b1;
            else if (cdone) begin
              scl_d = 1'b0; sb_d = {sb_q[6:0], 1'b0}; bc_d = bc_q + 4'd1;
              ph_d = (bc_d >= 4'd8) ? i2cee_pkg::PH_A0 : i2cee_pkg::PH_B0;
            end
          end
          i2cee_pkg::PH_A0: begin sda_d = 1'b1; ph_d = i2cee_pkg::PH_A1; end
          i2cee_pkg::PH_A1: begin scl_d = 1'b1; wc_d = '0; ph_d = i2cee_pkg::PH_A2; end
          i2cee_pkg::PH_A2: begin
            if (cto) pd = 1'b1;
            else if (cdone) begin scl_d = 1'b0; pd = 1'b1; pr = !item_i.sda_in; end
          end
          i2cee_pkg::PH_R0: begin
            scl_d = 1'b0; sda_d = 1'b1; ph_d = i2cee_pkg::PH_R1;
          end
          i2cee_pkg::PH_R1: begin scl_d = 1'b1; wc_d = '0; ph_d = i2cee_pkg::PH_R2; end
          i2cee_pkg::PH_R2: begin
            if (cto) pd = 1'b1;
            else if (cdone) begin
              sb_d = {sb_q[6:0], item_i.sda_in}; scl_d = 1'b0; bc_d = bc_q + 4'd1;
              ph_d = (bc_d >= 4'd8) ? i2cee_pkg::PH_R3 : i2cee_pkg::PH_R1;
            end
          end
          i2cee_pkg::PH_R3: begin sda_d = (bl_q <= 16'd1); ph_d = i2cee_pkg::PH_R4; end
          i2cee_pkg::PH_R4: begin scl_d = 1'b1; wc_d = '0; ph_d = i2cee_pkg::PH_R5; end
          i2cee_pkg::PH_R5: begin
            if (cto) pd = 1'b1;
            else if (cdone) begin
              scl_d = 1'b0; pend_valid = 1'b1; pend_rd = sb_q; ph_d = i2cee_pkg::PH_R6;
            end
          end
          i2cee_pkg::PH_R6: begin sda_d = 1'b1; pd = 1'b1; pr = 1'b1; end
          default: wc_d = wc_q; // idle and need: tick ignored
        endcase
      end
      i2cee_pkg::CMD_SUPPLY: begin
        if (ph_q == i2cee_pkg::PH_NEED) begin
          sb_d = item_i.wdata; bc_d = '0; ph_d = i2cee_pkg::PH_B0;
        end
      end
      default: begin
        if (ph_q == i2cee_pkg::PH_IDLE) begin
          if (item_i.length == 16'd0 || endaddr > 17'(MEM_BYTES)) begin
            pend_done = 1'b1;
          end else begin
            wr_d = (item_i.cmd == i2cee_pkg::CMD_WRITE);
            ca_d = item_i.mem_address; bl_d = item_i.length; ok_d = 1'b1;
            pc_d = '0; rdy_d = 1'b0; wp_d = !wr_d;
            if (wr_d) pl_d = page_of(item_i.mem_address, item_i.length);
            sq_d = i2cee_pkg::SQ_REC; ph_d = i2cee_pkg::PH_V0;
          end
        end
      end
    endcase

    // step completion dispatch
    if (pd) begin
      unique case (sq_q) inside
        i2cee_pkg::SQ_REC, i2cee_pkg::SQ_START1, i2cee_pkg::SQ_DEVW,
        i2cee_pkg::SQ_AHI, i2cee_pkg::SQ_ALO, i2cee_pkg::SQ_START2,
        i2cee_pkg::SQ_DEVR, i2cee_pkg::SQ_RDATA, i2cee_pkg::SQ_WDATA: begin
          if (!pr) begin
            ok_d = 1'b0;
            sq_d = wr_q ? i2cee_pkg::SQ_WSTOP : i2cee_pkg::SQ_STOPEND;
            ph_d = i2cee_pkg::PH_P0;
          end else begin
            bc_d = '0;
            unique case (sq_q)
              i2cee_pkg::SQ_REC: begin
                sq_d = i2cee_pkg::SQ_START1; ph_d = i2cee_pkg::PH_S0;
              end
              i2cee_pkg::SQ_START1: begin
                sq_d = i2cee_pkg::SQ_DEVW; sb_d = devb(cfg_i.device_address, 1'b0);
                ph_d = i2cee_pkg::PH_B0;
              end
              i2cee_pkg::SQ_DEVW: begin
                sq_d = i2cee_pkg::SQ_AHI; sb_d = {1'b0, ca_q[14:8]};
                ph_d = i2cee_pkg::PH_B0;
              end
              i2cee_pkg::SQ_AHI: begin
                sq_d = i2cee_pkg::SQ_ALO; sb_d = ca_q[7:0]; ph_d = i2cee_pkg::PH_B0;
              end
              i2cee_pkg::SQ_ALO: begin
                if (wr_q) begin sq_d = i2cee_pkg::SQ_WDATA; ph_d = i2cee_pkg::PH_NEED; end
                else begin sq_d = i2cee_pkg::SQ_START2; ph_d = i2cee_pkg::PH_S0; end
              end
              i2cee_pkg::SQ_START2: begin
                sq_d = i2cee_pkg::SQ_DEVR; sb_d = devb(cfg_i.device_address, 1'b1);
                ph_d = i2cee_pkg::PH_B0;
              end
              i2cee_pkg::SQ_DEVR: begin
                sq_d = i2cee_pkg::SQ_RDATA; sb_d = '0; ph_d = i2cee_pkg::PH_R0;
              end
              i2cee_pkg::SQ_RDATA: begin
                bl_d = bl_q - 16'd1; ca_d = ca_q + 15'd1;
                if (bl_d == 16'd0) begin
                  sq_d = i2cee_pkg::SQ_STOPEND; ph_d = i2cee_pkg::PH_P0;
                end else begin sb_d = '0; ph_d = i2cee_pkg::PH_R0; end
              end
              default: begin // write data byte
                if (pl_q != '0) pl_d = pl_q - PW'(1);
                bl_d = bl_q - 16'd1; ca_d = ca_q + 15'd1;
                if (pl_d == '0) begin
                  sq_d = i2cee_pkg::SQ_WSTOP; ph_d = i2cee_pkg::PH_P0;
                end else ph_d = i2cee_pkg::PH_NEED;
              end
            endcase
          end
        end
        i2cee_pkg::SQ_STOPEND: begin
          if (!pr) ok_d = 1'b0;
          ph_d = i2cee_pkg::PH_IDLE; wp_d = 1'b1; pend_done = 1'b1; pend_succ = ok_d;
        end
        i2cee_pkg::SQ_WSTOP: begin
          if (!pr) ok_d = 1'b0;
          if (!ok_d) begin
            ph_d = i2cee_pkg::PH_IDLE; wp_d = 1'b1; pend_done = 1'b1;
          end else if (cfg_i.poll_attempts == 6'd0) begin
            ok_d = 1'b0; ph_d = i2cee_pkg::PH_IDLE; wp_d = 1'b1; pend_done = 1'b1;
          end else begin
            pc_d = 6'd1; sq_d = i2cee_pkg::SQ_PWAIT; wc_d = '0; ph_d = i2cee_pkg::PH_WAIT;
          end
        end
        i2cee_pkg::SQ_PWAIT: begin sq_d = i2cee_pkg::SQ_PSTART; ph_d = i2cee_pkg::PH_S0; end
        i2cee_pkg::SQ_PSTART: begin
          if (pr) begin
            sq_d = i2cee_pkg::SQ_PDEV; sb_d = devb(cfg_i.device_address, 1'b0);
            bc_d = '0; ph_d = i2cee_pkg::PH_B0;
          end else begin
            rdy_d = 1'b0; sq_d = i2cee_pkg::SQ_PSTOP; ph_d = i2cee_pkg::PH_P0;
          end
        end
        i2cee_pkg::SQ_PDEV: begin
          rdy_d = pr; sq_d = i2cee_pkg::SQ_PSTOP; ph_d = i2cee_pkg::PH_P0;
        end
        default: begin // poll stop
          if (!pr) begin
            ok_d = 1'b0; ph_d = i2cee_pkg::PH_IDLE; wp_d = 1'b1; pend_done = 1'b1;
          end else if (!rdy_q) begin
            if (pc_q >= cfg_i.poll_attempts) begin
              ok_d = 1'b0; ph_d = i2cee_pkg::PH_IDLE; wp_d = 1'b1; pend_done = 1'b1;
            end else begin
              pc_d = pc_q + 6'd1; sq_d = i2cee_pkg::SQ_PWAIT; wc_d = '0;
              ph_d = i2cee_pkg::PH_WAIT;
            end
          end else if (bl_q == 16'd0) begin
            ph_d = i2cee_pkg::PH_IDLE; wp_d = 1'b1; pend_done = 1'b1; pend_succ = ok_q;
          end else begin
            pl_d = page_of(ca_q, bl_q); sq_d = i2cee_pkg::SQ_REC; ph_d = i2cee_pkg::PH_V0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= i2cee_pkg::PH_IDLE; sq_q <= i2cee_pkg::SQ_REC;
      wc_q <= '0; bc_q <= '0; sb_q <= '0; ca_q <= '0; bl_q <= '0; pl_q <= '0;
      pc_q <= '0; ok_q <= 1'b1; wr_q <= 1'b0; rdy_q <= 1'b0; sok_q <= 1'b0;
      scl_q <= 1'b1; sda_q <= 1'b1; wp_q <= 1'b1;
      res_o <= '0;
    end else if (step_i) begin
      ph_q <= ph_d; sq_q <= sq_d; wc_q <= wc_d; bc_q <= bc_d; sb_q <= sb_d;
      ca_q <= ca_d; bl_q <= bl_d; pl_q <= pl_d; pc_q <= pc_d; ok_q <= ok_d;
      wr_q <= wr_d; rdy_q <= rdy_d; sok_q <= sok_d;
      scl_q <= scl_d; sda_q <= sda_d; wp_q <= wp_d;
      res_o.scl_out       <= scl_d;
      res_o.sda_out       <= sda_d;
      res_o.write_protect <= wp_d;
      res_o.rdata         <= pend_rd;
      res_o.rdata_valid   <= pend_valid;
      res_o.need_data     <= (ph_d == i2cee_pkg::PH_NEED);
      res_o.done_res      <= pend_done;
      res_o.success       <= pend_done && pend_succ;
      res_o.busy_res      <= (ph_d != i2cee_pkg::PH_IDLE);
    end
  end
endmodule
